### hw/rtl/ddodo_pkg.sv
// shared types, constants and control store for the differential drive odometry block
package ddodo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int ITER_W       = $clog2(ATAN_ENTRIES + 1);

   localparam int CW       = 34;
   localparam int CSR_IDX_W = 1;

   localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

   localparam logic [31:0] DISTANCE_GAIN_RESET = 32'd104858;
   localparam logic [31:0] HEADING_GAIN_RESET  = 32'd26215;

   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_GAIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_GAIN  = 1'd1;

   typedef logic [3:0] upc_type;

   localparam upc_type STEP_WAIT   = 4'd0;
   localparam upc_type STEP_MH     = 4'd1;
   localparam upc_type STEP_MD     = 4'd2;
   localparam upc_type STEP_CINIT  = 4'd3;
   localparam upc_type STEP_RAD    = 4'd4;
   localparam upc_type STEP_CITER  = 4'd5;
   localparam upc_type STEP_XHI    = 4'd6;
   localparam upc_type STEP_XLO    = 4'd7;
   localparam upc_type STEP_XSUM   = 4'd8;
   localparam upc_type STEP_XADD   = 4'd9;
   localparam upc_type STEP_YHI    = 4'd10;
   localparam upc_type STEP_YLO    = 4'd11;
   localparam upc_type STEP_YSUM   = 4'd12;
   localparam upc_type STEP_YADD   = 4'd13;
   localparam upc_type STEP_RESULT = 4'd14;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_HEAD_ADD,
      OP_CORDIC_INIT,
      OP_RAD,
      OP_CORDIC_STEP,
      OP_PART,
      OP_SCALE,
      OP_ACCUM,
      OP_RESULT
   } op_type;

   typedef enum logic [2:0] {
      MUL_HEAD,
      MUL_DIST,
      MUL_RAD,
      MUL_TRIG_HI,
      MUL_TRIG_LO
   } mul_sel_type;

   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_NO_REQ,
      JMP_LOOP,
      JMP_OUT_BUSY
   } jmp_type;

   typedef struct packed {
      op_type      op;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        axis;
      jmp_type     jmp;
      upc_type     target;
      logic        fin;
   } ucode_type;

   typedef struct packed {
      op_type              op;
      logic                mul_en;
      mul_sel_type         mul_sel;
      logic                axis;
      logic [ITER_W-1:0]   iter;
      logic                fire;
   } ctl_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        heading;
      logic [31:0]        check_sum;
   } result_type;

   function automatic ucode_type uw(op_type op, logic mul_en, mul_sel_type ms, logic axis,
                                    jmp_type jmp, upc_type tgt, logic fin);
      ucode_type w;
      w.op      = op;
      w.mul_en  = mul_en;
      w.mul_sel = ms;
      w.axis    = axis;
      w.jmp     = jmp;
      w.target  = tgt;
      w.fin     = fin;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(upc_type pc);
      ucode_type w;
      unique case (pc)
         STEP_WAIT:   w = uw(OP_CAPTURE, 1'b0, MUL_HEAD, 1'b0, JMP_NO_REQ, STEP_WAIT, 1'b0);
         STEP_MH:     w = uw(OP_NOP, 1'b1, MUL_HEAD, 1'b0, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_MD:     w = uw(OP_HEAD_ADD, 1'b1, MUL_DIST, 1'b0, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_CINIT:  w = uw(OP_CORDIC_INIT, 1'b1, MUL_RAD, 1'b0, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_RAD:    w = uw(OP_RAD, 1'b0, MUL_RAD, 1'b0, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_CITER:  w = uw(OP_CORDIC_STEP, 1'b0, MUL_RAD, 1'b0, JMP_LOOP, STEP_CITER, 1'b0);
         STEP_XHI:    w = uw(OP_NOP, 1'b1, MUL_TRIG_HI, 1'b0, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_XLO:    w = uw(OP_PART, 1'b1, MUL_TRIG_LO, 1'b0, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_XSUM:   w = uw(OP_SCALE, 1'b0, MUL_TRIG_LO, 1'b0, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_XADD:   w = uw(OP_ACCUM, 1'b0, MUL_TRIG_LO, 1'b0, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_YHI:    w = uw(OP_NOP, 1'b1, MUL_TRIG_HI, 1'b1, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_YLO:    w = uw(OP_PART, 1'b1, MUL_TRIG_LO, 1'b1, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_YSUM:   w = uw(OP_SCALE, 1'b0, MUL_TRIG_LO, 1'b1, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_YADD:   w = uw(OP_ACCUM, 1'b0, MUL_TRIG_LO, 1'b1, JMP_NEVER, STEP_WAIT, 1'b0);
         STEP_RESULT: w = uw(OP_RESULT, 1'b0, MUL_TRIG_LO, 1'b0, JMP_OUT_BUSY, STEP_RESULT, 1'b1);
         default:     w = uw(OP_NOP, 1'b0, MUL_HEAD, 1'b0, JMP_ALWAYS, STEP_WAIT, 1'b0);
      endcase
      return w;
   endfunction

   // atan(2^-i) in 2^-32 turn units
   function automatic logic [29:0] atan_turn(logic [ITER_W-1:0] i);
      logic [29:0] v;
      case (i)
         5'd0:    v = 30'd536870912;
         5'd1:    v = 30'd316933406;
         5'd2:    v = 30'd167458907;
         5'd3:    v = 30'd85004756;
         5'd4:    v = 30'd42667331;
         5'd5:    v = 30'd21354463;
         5'd6:    v = 30'd10679838;
         5'd7:    v = 30'd5340245;
         5'd8:    v = 30'd2670163;
         5'd9:    v = 30'd1335087;
         5'd10:   v = 30'd667544;
         5'd11:   v = 30'd333772;
         5'd12:   v = 30'd166886;
         5'd13:   v = 30'd83443;
         5'd14:   v = 30'd41722;
         5'd15:   v = 30'd20861;
         5'd16:   v = 30'd10430;
         5'd17:   v = 30'd5215;
         5'd18:   v = 30'd2608;
         5'd19:   v = 30'd1304;
         5'd20:   v = 30'd652;
         5'd21:   v = 30'd326;
         5'd22:   v = 30'd163;
         5'd23:   v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/diff_drive_odometry.sv
// Requests are taken one at a time: a new one is accepted only after the result step, and the
//   pace is set by the iterative cordic loop and the single shared multiplier
//   under microcode control.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous: pose and heading clear to zero, gains return to their defaults.
// top level: configuration registers, output register and sequencer/datapath
module diff_drive_odometry (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [15:0]                   req_right_ticks,
   input  logic signed [15:0]                   req_left_ticks,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [31:0]                   rsp_pos_x,
   output logic signed [31:0]                   rsp_pos_y,
   output logic [15:0]                          rsp_heading,
   output logic [31:0]                          rsp_check_sum,
   input  logic                                 csr_write_en,
   input  logic [ddodo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                          csr_wdata
);
   import ddodo_pkg::*;

   logic [31:0] distance_gain_ff, heading_gain_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   result_type  res;
   ctl_type     ctl;
   logic        out_busy;
   logic        res_load;

   assign out_busy = rsp_valid_ff && rsp_stall;
   assign res_load = (ctl.op == OP_RESULT) && ctl.fire;

   ddodo_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .req_stall (req_stall),
      .ctl       (ctl)
   );

   ddodo_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_right_ticks (req_right_ticks),
      .req_left_ticks  (req_left_ticks),
      .distance_gain   (distance_gain_ff),
      .heading_gain    (heading_gain_ff),
      .res             (res)
   );

   always_comb begin
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distance_gain_ff <= DISTANCE_GAIN_RESET;
         heading_gain_ff  <= HEADING_GAIN_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_DISTANCE_GAIN: distance_gain_ff <= csr_wdata;
               CSR_HEADING_GAIN:  heading_gain_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = rsp_ff.pos_x;
   assign rsp_pos_y     = rsp_ff.pos_y;
   assign rsp_heading   = rsp_ff.heading;
   assign rsp_check_sum = rsp_ff.check_sum;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in work");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(res_load))
      else $error("result valid without a result step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending result overwritten");

endmodule

### hw/rtl/ddodo_seq.sv
// microcode sequencer: step counter, control store lookup, loop counter and jumps
module ddodo_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_busy,
   output logic              req_stall,
   output ddodo_pkg::ctl_type ctl
);
   import ddodo_pkg::*;

   upc_type           upc_ff, upc_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   ucode_type         w;
   logic              take;

   always_comb begin
      w = ucode_rom(upc_ff);
      case (w.jmp)
         JMP_NEVER:    take = 1'b0;
         JMP_ALWAYS:   take = 1'b1;
         JMP_NO_REQ:   take = !req_valid;
         JMP_LOOP:     take = (iter_ff != ITER_W'(CORDIC_N - 1));
         JMP_OUT_BUSY: take = out_busy;
         default:      take = 1'b0;
      endcase
      if (take) begin
         upc_in = w.target;
      end else if (w.fin) begin
         upc_in = STEP_WAIT;
      end else begin
         upc_in = upc_ff + 4'd1;
      end
      iter_in     = (w.op == OP_CORDIC_STEP) ? (iter_ff + ITER_W'(1)) : '0;
      ctl.op      = w.op;
      ctl.mul_en  = w.mul_en;
      ctl.mul_sel = w.mul_sel;
      ctl.axis    = w.axis;
      ctl.iter    = iter_ff;
      ctl.fire    = !((w.jmp == JMP_NO_REQ) && !req_valid) &&
                    !((w.jmp == JMP_OUT_BUSY) && out_busy);
      req_stall   = (w.op != OP_CAPTURE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= STEP_WAIT;
         iter_ff <= '0;
      end else begin
         upc_ff  <= upc_in;
         iter_ff <= iter_in;
      end
   end

   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_CORDIC_STEP) |-> (iter_ff < ITER_W'(CORDIC_N)))
      else $error("cordic loop counter past last step");

   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= STEP_RESULT)
      else $error("step counter outside program");

endmodule

### hw/rtl/ddodo_dp.sv
// datapath: shared multiplier, cordic rotator, pose accumulators and result formatting
module ddodo_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ddodo_pkg::ctl_type    ctl,
   input  logic signed [15:0]    req_right_ticks,
   input  logic signed [15:0]    req_left_ticks,
   input  logic [31:0]           distance_gain,
   input  logic [31:0]           heading_gain,
   output ddodo_pkg::result_type res
);
   import ddodo_pkg::*;

   logic signed [16:0]   diff_ff, sum_ff;
   logic signed [65:0]   prod_ff;
   logic [55:0]          part_ff;
   logic [31:0]          heading_ff;
   logic                 dist_neg_ff;
   logic [47:0]          dist_mag_ff;
   logic [18:0]          rad_ff;
   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff;
   logic                 flip_ff;
   logic signed [50:0]   delta_ff;
   logic signed [63:0]   xacc_ff, yacc_ff;

   logic signed [32:0]   a_op, b_op;
   logic signed [65:0]   mul_full;
   logic signed [CW-1:0] trig_sel, trig_abs, xs, ys, at;
   logic                 trig_neg;
   logic [32:0]          trig_mag;
   logic                 flip_c;
   logic signed [65:0]   dist_abs;
   logic [79:0]          tot;
   logic [50:0]          mag51;
   logic signed [63:0]   acc_sel;
   logic signed [64:0]   acc_sum;
   logic signed [63:0]   acc_sat;
   logic [31:0]          px, py;

   function automatic logic [31:0] clamp_pos(logic signed [63:0] acc);
      logic [47:0] v;
      v = acc[63:16];
      if (v[47:31] == {17{v[47]}}) begin
         return v[31:0];
      end else begin
         return v[47] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
   endfunction

   always_comb begin
      trig_sel = ctl.axis ? cy_ff : cx_ff;
      trig_neg = flip_ff ? (trig_sel > 0) : (trig_sel < 0);
      trig_abs = trig_sel[CW-1] ? (-trig_sel) : trig_sel;
      trig_mag = trig_abs[32:0];
      case (ctl.mul_sel)
         MUL_HEAD: begin
            a_op = {1'b0, heading_gain};
            b_op = 33'(diff_ff);
         end
         MUL_DIST: begin
            a_op = {1'b0, distance_gain};
            b_op = 33'(sum_ff);
         end
         MUL_RAD: begin
            a_op = {1'b0, heading_ff};
            b_op = {1'b0, TWO_PI_Q29};
         end
         MUL_TRIG_HI: begin
            a_op = trig_mag;
            b_op = {9'b0, dist_mag_ff[47:24]};
         end
         MUL_TRIG_LO: begin
            a_op = trig_mag;
            b_op = {9'b0, dist_mag_ff[23:0]};
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
      mul_full = a_op * b_op;
      flip_c   = heading_ff[31] ^ heading_ff[30];
      dist_abs = prod_ff[65] ? (-prod_ff) : prod_ff;
      xs       = cx_ff >>> ctl.iter;
      ys       = cy_ff >>> ctl.iter;
      at       = {4'b0, atan_turn(ctl.iter)};
      tot      = {part_ff, 24'b0} + {24'b0, prod_ff[55:0]};
      mag51    = {1'b0, tot[79:30]};
      acc_sel  = ctl.axis ? yacc_ff : xacc_ff;
      acc_sum  = 65'(acc_sel) + 65'(delta_ff);
      if (acc_sum[64] != acc_sum[63]) begin
         acc_sat = acc_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end else begin
         acc_sat = acc_sum[63:0];
      end
      px = clamp_pos(xacc_ff);
      py = clamp_pos(yacc_ff);
      res.pos_x     = px;
      res.pos_y     = py;
      res.heading   = heading_ff[31:16];
      res.check_sum = 32'(rad_ff) + px + py;
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      if (ctl.op == OP_CAPTURE && ctl.fire) begin
         diff_ff <= 17'(req_right_ticks) - 17'(req_left_ticks);
         sum_ff  <= 17'(req_right_ticks) + 17'(req_left_ticks);
      end
      if (ctl.mul_en) begin
         prod_ff <= mul_full;
      end
      if (ctl.op == OP_CORDIC_INIT) begin
         dist_neg_ff <= prod_ff[65];
         dist_mag_ff <= dist_abs[47:0];
         flip_ff     <= flip_c;
         cx_ff       <= CORDIC_START;
         cy_ff       <= '0;
         cz_ff       <= CW'(signed'({heading_ff[31] ^ flip_c, heading_ff[30:0]}));
      end
      if (ctl.op == OP_RAD) begin
         rad_ff <= prod_ff[63:45];
      end
      if (ctl.op == OP_CORDIC_STEP) begin
         if (!cz_ff[CW-1]) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - at;
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + at;
         end
      end
      if (ctl.op == OP_PART) begin
         part_ff <= prod_ff[55:0];
      end
      if (ctl.op == OP_SCALE) begin
         delta_ff <= (dist_neg_ff ^ trig_neg) ? -signed'(mag51) : signed'(mag51);
      end
   end

   // pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= '0;
         xacc_ff    <= '0;
         yacc_ff    <= '0;
      end else begin
         if (ctl.op == OP_HEAD_ADD) begin
            heading_ff <= heading_ff + prod_ff[31:0];
         end
         if (ctl.op == OP_ACCUM) begin
            if (ctl.axis) begin
               yacc_ff <= acc_sat;
            end else begin
               xacc_ff <= acc_sat;
            end
         end
      end
   end

endmodule
